// ===== sv/bti_pkg.sv =====
// Shared types and constants for the breakpoint table interpolator.
package bti_pkg;

	localparam int TABLE_POINTS = 16;
	localparam int IDX_W        = (TABLE_POINTS > 1) ? $clog2(TABLE_POINTS) : 1;
	localparam int DATA_W       = 32;
	localparam int CNT_W        = 5;
	localparam int ALU_W        = DATA_W + 2;
	localparam int PROD_W       = 2 * DATA_W;
	localparam int STEP_W       = $clog2(PROD_W);

	typedef enum logic [2:0] {
		ST_INTERP  = 3'd0,
		ST_BELOW   = 3'd1,
		ST_ABOVE   = 3'd2,
		ST_EMPTY   = 3'd3,
		ST_NO_SEG  = 3'd4
	} status_t;

	typedef enum logic {
		ALU_SUB = 1'b0,
		ALU_ADD = 1'b1
	} alu_op_t;

	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

endpackage

// ===== sv/bti_table.sv =====
// Breakpoint storage: one write port, one registered read port.
module bti_table
	import bti_pkg::*;
(
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [IDX_W-1:0]         wr_addr,
	input  logic signed [DATA_W-1:0] wr_x,
	input  logic signed [DATA_W-1:0] wr_y,
	input  logic [IDX_W-1:0]         rd_addr,
	output logic signed [DATA_W-1:0] rd_x,
	output logic signed [DATA_W-1:0] rd_y
);

	logic signed [DATA_W-1:0] mem_x [TABLE_POINTS];
	logic signed [DATA_W-1:0] mem_y [TABLE_POINTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[wr_addr] <= wr_x;
			mem_y[wr_addr] <= wr_y;
		end
		rd_x <= mem_x[rd_addr];
		rd_y <= mem_y[rd_addr];
	end

endmodule

// ===== sv/bti_alu.sv =====
// Shared add/subtract unit used for compares, differences, division steps and the final add.
module bti_alu
	import bti_pkg::*;
(
	input  alu_op_t                 op,
	input  logic signed [ALU_W-1:0] a,
	input  logic signed [ALU_W-1:0] b,
	output logic signed [ALU_W-1:0] res
);

	always_comb begin
		unique case (op)
			ALU_ADD: res = a + b;
			ALU_SUB: res = a - b;
			default: res = a - b;
		endcase
	end

endmodule

// ===== sv/breakpoint_table_interpolator.sv =====
// Breakpoint table interpolator: top level with sequencer, shared ALU and multiplier.
//
// One-dimensional breakpoint table (TABLE_POINTS entries) with linear interpolation.
// A write item stores one (x, y) pair and is ready for the next item at once. A
// lookup walks the table through the single read port of the table memory and one
// shared 34-bit add/subtract unit: clamp checks in S_FIRST and S_LAST, then
// S_SCAN_LO and S_SCAN_HI for each segment examined, setup in S_DX, S_NUM, S_DY
// and, for a falling segment, S_NEG, a 32x32 multiply in S_MUL, 64 restoring-division
// steps on that same unit, one add, and S_DONE to load the output register. An
// empty table, a sample at or below the first x or at or above the last x, and a
// zero-width segment end the lookup early. in_stall is high while a lookup is in
// progress and while its result waits for the output register to free up. A result
// sits in the output register until taken, and the next item may be transferred
// meanwhile. points_in_use (n_q) is to be written via cfg_we/cfg_wdata only while
// idle; the block itself does not enforce this. Values above TABLE_POINTS saturate.
// Breakpoints must be written before a lookup reads them.
module breakpoint_table_interpolator
	import bti_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CNT_W-1:0]         cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     action,
	input  logic [3:0]               point_index,
	input  logic signed [DATA_W-1:0] point_x,
	input  logic signed [DATA_W-1:0] point_y,
	input  logic signed [DATA_W-1:0] sample,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] value,
	output status_t                  status
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIRST,
		S_LAST,
		S_SCAN_LO,
		S_SCAN_HI,
		S_DX,
		S_NUM,
		S_DY,
		S_NEG,
		S_MUL,
		S_DIV,
		S_ADD,
		S_DONE
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         n_q;
	logic [CNT_W-1:0]         idx_q;
	logic signed [DATA_W-1:0] s_q;
	logic signed [DATA_W-1:0] xa_q, ya_q, xb_q, yb_q;
	logic [DATA_W-1:0]        den_q, num_q, mag_q;
	logic                     neg_q;
	logic [PROD_W-1:0]        prod_q;
	logic [DATA_W-1:0]        rem_q;
	logic [STEP_W-1:0]        cnt_q;
	logic signed [DATA_W-1:0] rv_q;
	status_t                  rs_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] value_q;
	status_t                  status_q;

	logic                     in_xfer;
	logic                     tbl_wr;
	logic [IDX_W-1:0]         rd_addr;
	logic signed [DATA_W-1:0] rd_x, rd_y;
	alu_op_t                  alu_op;
	logic signed [ALU_W-1:0]  alu_a, alu_b, alu_res;
	logic                     alu_neg, alu_zero;
	logic [DATA_W:0]          div_r;
	logic [CNT_W-1:0]         idx_nxt;
	logic                     last_seg;

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign tbl_wr    = in_xfer && (action == ACT_WRITE) &&
		(32'(point_index) < TABLE_POINTS);
	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

	assign idx_nxt   = idx_q + CNT_W'(1);
	assign last_seg  = (idx_nxt == n_q);
	assign div_r     = {rem_q, prod_q[PROD_W-1]};
	assign alu_neg   = alu_res[ALU_W-1];
	assign alu_zero  = (alu_res == '0);

	bti_table u_table (
		.clk     (clk),
		.wr_en   (tbl_wr),
		.wr_addr (IDX_W'(point_index)),
		.wr_x    (point_x),
		.wr_y    (point_y),
		.rd_addr (rd_addr),
		.rd_x    (rd_x),
		.rd_y    (rd_y)
	);

	bti_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res)
	);

	// Read address: entry whose data is needed in the following state.
	always_comb begin
		unique case (state_q)
			S_IDLE:    rd_addr = '0;
			S_FIRST:   rd_addr = IDX_W'(n_q - CNT_W'(1));
			S_LAST:    rd_addr = IDX_W'(1);
			S_SCAN_LO,
			S_SCAN_HI: rd_addr = IDX_W'(idx_nxt);
			default:   rd_addr = IDX_W'(idx_q);
		endcase
	end

	// Operand selection for the shared unit.
	always_comb begin
		alu_op = ALU_SUB;
		alu_a  = ALU_W'(s_q);
		alu_b  = ALU_W'(rd_x);
		unique case (state_q)
			S_FIRST, S_LAST: begin
				alu_a = ALU_W'(s_q);
				alu_b = ALU_W'(rd_x);
			end
			S_SCAN_LO, S_NUM: begin
				alu_a = ALU_W'(s_q);
				alu_b = ALU_W'(xa_q);
			end
			S_SCAN_HI: begin
				alu_a = ALU_W'(xb_q);
				alu_b = ALU_W'(s_q);
			end
			S_DX: begin
				alu_a = ALU_W'(xb_q);
				alu_b = ALU_W'(xa_q);
			end
			S_DY: begin
				alu_a = ALU_W'(yb_q);
				alu_b = ALU_W'(ya_q);
			end
			S_NEG: begin
				alu_a = ALU_W'(ya_q);
				alu_b = ALU_W'(yb_q);
			end
			S_DIV: begin
				alu_a = ALU_W'(div_r);
				alu_b = ALU_W'(den_q);
			end
			S_ADD: begin
				alu_op = neg_q ? ALU_SUB : ALU_ADD;
				alu_a  = ALU_W'(ya_q);
				alu_b  = ALU_W'(prod_q[DATA_W-1:0]);
			end
			default: begin
				alu_op = ALU_SUB;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			n_q         <= '0;
			idx_q       <= '0;
			s_q         <= '0;
			xa_q        <= '0;
			ya_q        <= '0;
			xb_q        <= '0;
			yb_q        <= '0;
			den_q       <= '0;
			num_q       <= '0;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			prod_q      <= '0;
			rem_q       <= '0;
			cnt_q       <= '0;
			rv_q        <= '0;
			rs_q        <= ST_EMPTY;
			out_valid_q <= 1'b0;
			value_q     <= '0;
			status_q    <= ST_EMPTY;
		end else begin
			if (cfg_we) begin
				n_q <= (32'(cfg_wdata) > TABLE_POINTS) ? CNT_W'(TABLE_POINTS) : cfg_wdata;
			end
			// S_DONE reloads the output register itself
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_xfer && (action == ACT_LOOKUP)) begin
						s_q   <= sample;
						neg_q <= 1'b0;
						if (n_q == '0) begin
							rv_q    <= '0;
							rs_q    <= ST_EMPTY;
							state_q <= S_DONE;
						end else begin
							state_q <= S_FIRST;
						end
					end
				end
				S_FIRST: begin
					// s <= x0
					if (alu_neg || alu_zero) begin
						rv_q    <= rd_y;
						rs_q    <= ST_BELOW;
						state_q <= S_DONE;
					end else begin
						xa_q    <= rd_x;
						ya_q    <= rd_y;
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					if (!alu_neg) begin
						rv_q    <= rd_y;
						rs_q    <= ST_ABOVE;
						state_q <= S_DONE;
					end else begin
						idx_q   <= CNT_W'(1);
						state_q <= S_SCAN_LO;
					end
				end
				S_SCAN_LO: begin
					xb_q <= rd_x;
					yb_q <= rd_y;
					if (!alu_neg) begin
						state_q <= S_SCAN_HI;
					end else if (last_seg) begin
						rv_q    <= '0;
						rs_q    <= ST_NO_SEG;
						state_q <= S_DONE;
					end else begin
						xa_q  <= rd_x;
						ya_q  <= rd_y;
						idx_q <= idx_nxt;
					end
				end
				S_SCAN_HI: begin
					if (!alu_neg) begin
						state_q <= S_DX;
					end else if (last_seg) begin
						rv_q    <= '0;
						rs_q    <= ST_NO_SEG;
						state_q <= S_DONE;
					end else begin
						xa_q    <= xb_q;
						ya_q    <= yb_q;
						idx_q   <= idx_nxt;
						state_q <= S_SCAN_LO;
					end
				end
				S_DX: begin
					den_q <= alu_res[DATA_W-1:0];
					if (alu_zero) begin
						rv_q    <= ya_q;
						rs_q    <= ST_INTERP;
						state_q <= S_DONE;
					end else begin
						state_q <= S_NUM;
					end
				end
				S_NUM: begin
					num_q   <= alu_res[DATA_W-1:0];
					state_q <= S_DY;
				end
				S_DY: begin
					mag_q <= alu_res[DATA_W-1:0];
					if (alu_neg) begin
						neg_q   <= 1'b1;
						state_q <= S_NEG;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_NEG: begin
					mag_q   <= alu_res[DATA_W-1:0];
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= PROD_W'(num_q) * PROD_W'(mag_q);
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					// restoring step: quotient bits shift in at the bottom
					if (!alu_neg) begin
						rem_q  <= alu_res[DATA_W-1:0];
						prod_q <= {prod_q[PROD_W-2:0], 1'b1};
					end else begin
						rem_q  <= div_r[DATA_W-1:0];
						prod_q <= {prod_q[PROD_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q + STEP_W'(1);
					if (cnt_q == STEP_W'(PROD_W - 1)) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					rv_q    <= alu_res[DATA_W-1:0];
					rs_q    <= ST_INTERP;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						value_q     <= rv_q;
						status_q    <= rs_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the breakpoint table interpolator: directed rows, then random phases.
module testbench;
	import bti_pkg::*;

	localparam logic signed [DATA_W-1:0] MIN_S = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] MAX_S = 32'sh7fff_ffff;
	localparam int RANDOM_ITEMS = 1700;
	localparam int SETTLE_CYCLES = 150;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		status_t                  status;
	} lookup_result_t;

	typedef enum logic [1:0] {
		ROW_SET_POINTS,
		ROW_WRITE,
		ROW_LOOKUP
	} row_kind_t;

	// write: a = x, b = y, arg = slot; lookup: a = sample; set: arg = count
	typedef struct packed {
		row_kind_t                kind;
		logic [CNT_W-1:0]         arg;
		logic signed [DATA_W-1:0] a;
		logic signed [DATA_W-1:0] b;
		logic                     chk;
		logic signed [DATA_W-1:0] want_v;
		status_t                  want_st;
	} directed_row_t;

	localparam directed_row_t DIRECTED [0:20] = '{
		'{ROW_LOOKUP,     5'd0,  MIN_S,           32'sd0,     1'b1, 32'sd0, ST_EMPTY},
		'{ROW_LOOKUP,     5'd0,  MAX_S,           32'sd0,     1'b1, 32'sd0, ST_EMPTY},
		'{ROW_LOOKUP,     5'd0,  32'sd0,          32'sd0,     1'b1, 32'sd0, ST_EMPTY},
		'{ROW_WRITE,      5'd0,  MIN_S,           MAX_S,      1'b0, 32'sd0, ST_INTERP},
		'{ROW_WRITE,      5'd1,  32'sd0,          MIN_S,      1'b0, 32'sd0, ST_INTERP},
		'{ROW_WRITE,      5'd2,  MAX_S,           32'sd0,     1'b0, 32'sd0, ST_INTERP},
		'{ROW_SET_POINTS, 5'd1,  32'sd0,          32'sd0,     1'b0, 32'sd0, ST_INTERP},
		'{ROW_LOOKUP,     5'd0,  MIN_S,           32'sd0,     1'b1, MAX_S,  ST_BELOW},
		'{ROW_LOOKUP,     5'd0,  -32'sd5,         32'sd0,     1'b1, MAX_S,  ST_ABOVE},
		'{ROW_LOOKUP,     5'd0,  MAX_S,           32'sd0,     1'b1, MAX_S,  ST_ABOVE},
		'{ROW_SET_POINTS, 5'd3,  32'sd0,          32'sd0,     1'b0, 32'sd0, ST_INTERP},
		'{ROW_LOOKUP,     5'd0,  MIN_S,           32'sd0,     1'b1, MAX_S,  ST_BELOW},
		'{ROW_LOOKUP,     5'd0,  MAX_S,           32'sd0,     1'b1, 32'sd0, ST_ABOVE},
		'{ROW_LOOKUP,     5'd0,  MIN_S + 32'sd1,  32'sd0,     1'b0, 32'sd0, ST_INTERP},
		'{ROW_LOOKUP,     5'd0,  -32'sd1,         32'sd0,     1'b0, 32'sd0, ST_INTERP},
		'{ROW_LOOKUP,     5'd0,  32'sd0,          32'sd0,     1'b0, 32'sd0, ST_INTERP},
		'{ROW_LOOKUP,     5'd0,  32'sd1,          32'sd0,     1'b0, 32'sd0, ST_INTERP},
		'{ROW_LOOKUP,     5'd0,  MAX_S - 32'sd1,  32'sd0,     1'b0, 32'sd0, ST_INTERP},
		// first two x equal: zero-width first segment
		'{ROW_WRITE,      5'd1,  MIN_S,           32'sd12345, 1'b0, 32'sd0, ST_INTERP},
		'{ROW_LOOKUP,     5'd0,  -32'sd1,         32'sd0,     1'b0, 32'sd0, ST_INTERP},
		'{ROW_LOOKUP,     5'd0,  MIN_S,           32'sd0,     1'b1, MAX_S,  ST_BELOW}
	};

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CNT_W-1:0]         cfg_wdata = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     action = ACT_WRITE;
	logic [3:0]               point_index = '0;
	logic signed [DATA_W-1:0] point_x = '0;
	logic signed [DATA_W-1:0] point_y = '0;
	logic signed [DATA_W-1:0] sample = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [DATA_W-1:0] value;
	status_t                  status;

	// predictor copy of the table and the count register
	logic signed [DATA_W-1:0] bp_x [TABLE_POINTS];
	logic signed [DATA_W-1:0] bp_y [TABLE_POINTS];
	int unsigned              active_points;

	lookup_result_t expected_results [$];
	int  error_count;
	int  random_items;
	bit  calm;

	breakpoint_table_interpolator DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.point_index(point_index),
		.point_x    (point_x),
		.point_y    (point_y),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.value      (value),
		.status     (status)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic lookup_result_t predict_lookup(input logic signed [DATA_W-1:0] s);
		lookup_result_t r;
		longint ss, x0, x1, y0, y1, dy;
		bit [63:0] num, den, mag, q;
		int i, n;
		r.value = '0;
		r.status = ST_EMPTY;
		n = active_points;
		ss = longint'(s);
		if (n == 0) begin
			r.status = ST_EMPTY;
		end else if (ss <= longint'(bp_x[0])) begin
			r.value = bp_y[0];
			r.status = ST_BELOW;
		end else if (ss >= longint'(bp_x[n-1])) begin
			r.value = bp_y[n-1];
			r.status = ST_ABOVE;
		end else begin
			r.status = ST_NO_SEG;
			for (i = 0; i + 1 < n && r.status == ST_NO_SEG; i++) begin
				x0 = longint'(bp_x[i]);
				x1 = longint'(bp_x[i+1]);
				if (ss >= x0 && ss <= x1) begin
					y0 = longint'(bp_y[i]);
					y1 = longint'(bp_y[i+1]);
					r.status = ST_INTERP;
					if (x1 == x0) begin
						r.value = DATA_W'(y0);
					end else begin
						num = ss - x0;
						den = x1 - x0;
						dy = y1 - y0;
						mag = (dy < 0) ? -dy : dy;
						// both factors below 2^32, so the product fits in 64 bits
						q = (num * mag) / den;
						r.value = DATA_W'((dy < 0) ? y0 - longint'(q) : y0 + longint'(q));
					end
				end
			end
		end
		return r;
	endfunction

	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_coord(input int style);
		case (style)
			1: return $urandom_range(0, 40) - 20;
			2: begin
				case ($urandom_range(0, 3))
					0: return MIN_S;
					1: return MAX_S;
					default: return $urandom;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_sample();
		int r, k, n;
		longint lo, hi;
		bit [63:0] rnd, span;
		r = $urandom_range(0, 99);
		n = active_points;
		if (n > 0 && r < 55) begin
			lo = longint'(bp_x[0]);
			hi = longint'(bp_x[n-1]);
			if (hi > lo) begin
				rnd = {$urandom, $urandom};
				span = hi - lo + 1;
				return DATA_W'(lo + longint'(rnd % span));
			end
		end
		if (n > 0 && r < 75) begin
			k = $urandom_range(0, n - 1);
			return bp_x[k] + $urandom_range(0, 2) - 1;
		end
		if (r < 85) begin
			case ($urandom_range(0, 4))
				0: return MIN_S;
				1: return MAX_S;
				2: return 0;
				3: return -1;
				default: return 1;
			endcase
		end
		return $urandom;
	endfunction

	task automatic report_mismatch(input string what);
		error_count++;
		$display("%0t mismatch: %s", $time, what);
	endtask

	task automatic check_result();
		lookup_result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch($sformatf("result with nothing expected, value %0d", value));
		end else begin
			want = expected_results.pop_front();
			if (value !== want.value)
				report_mismatch($sformatf("value got %0d want %0d", value, want.value));
			if (status !== want.status)
				report_mismatch($sformatf("status got %0d want %0d", status, want.status));
		end
	endtask

	// Call at a rising edge; returns at the edge where the transfer happens.
	task automatic send_item(input logic act, input logic [3:0] slot,
			input logic signed [DATA_W-1:0] px, input logic signed [DATA_W-1:0] py,
			input logic signed [DATA_W-1:0] smp, input bit typed, input lookup_result_t want);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		action      <= act;
		point_index <= slot;
		point_x     <= px;
		point_y     <= py;
		sample      <= smp;
		do @(posedge clk); while (in_stall);
		if (act == ACT_WRITE) begin
			bp_x[slot] = px;
			bp_y[slot] = py;
		end else begin
			expected_results.push_back(typed ? want : predict_lookup(smp));
		end
	endtask

	task automatic wait_idle(input int settle);
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic set_points(input logic [CNT_W-1:0] count);
		wait_idle(8);
		cfg_we    <= 1'b1;
		cfg_wdata <= count;
		@(posedge clk);
		cfg_we <= 1'b0;
		active_points = (count > TABLE_POINTS) ? TABLE_POINTS : count;
	endtask

	task automatic random_phase(input int phase);
		logic signed [DATA_W-1:0] tx [TABLE_POINTS];
		logic signed [DATA_W-1:0] ty [TABLE_POINTS];
		logic signed [DATA_W-1:0] key;
		logic [CNT_W-1:0] count;
		lookup_result_t none;
		int shape, i, j, r, lookups;
		none = '0;
		calm = ($urandom_range(0, 3) == 0);
		if (phase == 0 || $urandom_range(0, 9) < 6) begin
			shape = $urandom_range(0, 9);
			for (i = 0; i < TABLE_POINTS; i++) begin
				tx[i] = pick_coord(shape >= 6 && shape <= 7 ? 1 : (shape == 9 ? 2 : 0));
				ty[i] = pick_coord($urandom_range(0, 4) == 0 ? 2 : 0);
			end
			// most tables sorted by x; shape 8 stays unsorted
			if (shape != 8) begin
				for (i = 1; i < TABLE_POINTS; i++) begin
					key = tx[i];
					j = i - 1;
					while (j >= 0 && tx[j] > key) begin
						tx[j+1] = tx[j];
						j--;
					end
					tx[j+1] = key;
				end
			end
			for (i = 0; i < TABLE_POINTS; i++) begin
				send_item(ACT_WRITE, 4'(i), tx[i], ty[i], $urandom, 1'b0, none);
				random_items++;
			end
		end
		if (phase < 4) begin
			case (phase)
				0: count = CNT_W'(16);
				1: count = CNT_W'(31);
				2: count = CNT_W'(1);
				default: count = CNT_W'(0);
			endcase
		end else begin
			r = $urandom_range(0, 99);
			if (r < 10)
				count = CNT_W'(0);
			else if (r < 20)
				count = CNT_W'(1);
			else if (r < 45)
				count = CNT_W'(16);
			else if (r < 60)
				count = CNT_W'($urandom_range(17, 31));
			else
				count = CNT_W'($urandom_range(2, 15));
		end
		set_points(count);
		lookups = $urandom_range(30, 90);
		for (i = 0; i < lookups; i++) begin
			if ($urandom_range(0, 99) < 8)
				send_item(ACT_WRITE, 4'($urandom_range(0, 15)), $urandom, $urandom, $urandom,
					1'b0, none);
			else
				send_item(ACT_LOOKUP, 4'($urandom_range(0, 15)), $urandom, $urandom,
					pick_sample(), 1'b0, none);
			random_items++;
		end
	endtask

	initial begin : stimulus
		int k, phase;
		lookup_result_t want;
		error_count = 0;
		random_items = 0;
		calm = 1'b0;
		active_points = 0;
		for (k = 0; k < TABLE_POINTS; k++) begin
			bp_x[k] = '0;
			bp_y[k] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (k = 0; k < $size(DIRECTED); k++) begin
			want.value = DIRECTED[k].want_v;
			want.status = DIRECTED[k].want_st;
			case (DIRECTED[k].kind)
				ROW_SET_POINTS: set_points(DIRECTED[k].arg);
				ROW_WRITE: send_item(ACT_WRITE, DIRECTED[k].arg[3:0], DIRECTED[k].a,
					DIRECTED[k].b, 32'sd0, 1'b0, want);
				default: send_item(ACT_LOOKUP, 4'd0, 32'sd0, 32'sd0, DIRECTED[k].a,
					DIRECTED[k].chk, want);
			endcase
		end
		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			random_phase(phase);
			phase++;
		end
		wait_idle(SETTLE_CYCLES);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin : result_sink
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				check_result();
			if (hold > 0)
				hold--;
			else
				hold = idle_cycles();
			out_stall <= (hold > 0);
		end
	end

	initial begin : watchdog
		#20_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
sv/bti_pkg.sv
sv/bti_table.sv
sv/bti_alu.sv
sv/breakpoint_table_interpolator.sv
dv/testbench.sv
